// ===== src/shbi_pkg.sv =====
package shbi_pkg;

    localparam int unsigned HASH_W  = 32;
    localparam int unsigned BYTE_W  = 8;

    typedef logic [HASH_W-1:0] t_hash;
    typedef logic [BYTE_W-1:0] t_byte;

    localparam int unsigned ABSORB_SHL = 10;
    localparam int unsigned ABSORB_SHR = 6;
    localparam int unsigned MIX_SHL_A  = 3;
    localparam int unsigned MIX_SHR    = 11;
    localparam int unsigned MIX_SHL_B  = 15;

    localparam t_hash BUCKET_COUNT_RESET = 32'd13;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== src/shbi_key_if.sv =====
interface shbi_key_if;
    logic             valid;
    logic             ready;
    shbi_pkg::t_byte  key_byte;
    logic             end_of_key;

    modport source (output valid, output key_byte, output end_of_key, input ready);
    modport sink   (input valid, input key_byte, input end_of_key, output ready);
endinterface

// ===== src/shbi_cfg_if.sv =====
interface shbi_cfg_if;
    logic             valid;
    logic             ready;
    shbi_pkg::t_hash  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/shbi_bucket_if.sv =====
interface shbi_bucket_if;
    logic             valid;
    logic             ready;
    shbi_pkg::t_hash  bucket_index;

    modport source (output valid, output bucket_index, input ready);
    modport sink   (input valid, input bucket_index, output ready);
endinterface

// ===== src/shbi_front.sv =====
module shbi_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    shbi_key_if.sink              i_key,
    input  shbi_pkg::t_q_status   i_q_status,
    output logic                  o_q_push,
    output shbi_pkg::t_hash       o_q_data
);
    import shbi_pkg::*;

    t_hash r_hash;
    t_hash n_sum;
    t_hash n_hash;
    logic  n_accept;

    assign i_key.ready = !i_q_status.full;
    assign n_accept    = i_key.valid && i_key.ready;

    always_comb begin
        n_sum  = r_hash + {{(HASH_W-BYTE_W){1'b0}}, i_key.key_byte};
        n_sum  = n_sum + (n_sum << ABSORB_SHL);
        n_hash = n_sum ^ (n_sum >> ABSORB_SHR);
    end

    assign o_q_push = n_accept && i_key.end_of_key;
    assign o_q_data = r_hash;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= '0;
        end else if (n_accept) begin
            if (i_key.end_of_key) begin
                r_hash <= '0;
            end else begin
                r_hash <= n_hash;
            end
        end
    end

endmodule

// ===== src/shbi_queue.sv =====
module shbi_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  shbi_pkg::t_hash       i_push_data,
    input  logic                  i_pop,
    output shbi_pkg::t_hash       o_pop_data,
    output shbi_pkg::t_q_status   o_status
);
    import shbi_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_hash           r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            n_push;
    logic            n_pop;

    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_pop_data     = r_mem[r_rd_ptr];
    assign n_push         = i_push && !o_status.full;
    assign n_pop          = i_pop && !o_status.empty;

    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (n_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (n_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (n_push && !n_pop) begin
                r_count <= r_count + 1'b1;
            end else if (n_pop && !n_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_status.full))
        else $error("Queue written while full.");

    a_count_bounded : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("Queue fill count exceeds its depth.");
`endif

endmodule

// ===== src/shbi_back.sv =====
module shbi_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  shbi_pkg::t_hash       i_bucket_count,
    input  shbi_pkg::t_hash       i_q_data,
    input  shbi_pkg::t_q_status   i_q_status,
    output logic                  o_q_pop,
    shbi_bucket_if.source         o_bucket
);
    import shbi_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MIX,
        S_DIV,
        S_OUT
    } t_state;

    localparam int unsigned SW = $clog2(HASH_W);

    t_state           r_state;
    logic [1:0]       r_step;
    logic [SW-1:0]    r_bit;
    t_hash            r_acc;
    t_hash            r_rem;
    t_hash            n_mix;
    logic [HASH_W:0]  n_shift;
    logic [HASH_W+1:0] n_diff;

    assign o_q_pop               = (r_state == S_IDLE) && !i_q_status.empty;
    assign o_bucket.valid        = (r_state == S_OUT);
    assign o_bucket.bucket_index = r_acc;

    always_comb begin
        unique case (r_step)
            2'd0:    n_mix = r_acc + (r_acc << MIX_SHL_A);
            2'd1:    n_mix = r_acc ^ (r_acc >> MIX_SHR);
            default: n_mix = r_acc + (r_acc << MIX_SHL_B);
        endcase
    end

    always_comb begin
        n_shift = {r_rem, r_acc[HASH_W-1]};
        n_diff  = {1'b0, n_shift} - {2'b00, i_bucket_count};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_bit   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_status.empty) begin
                        r_acc   <= i_q_data;
                        r_step  <= '0;
                        r_state <= S_MIX;
                    end
                end
                S_MIX: begin
                    r_acc  <= n_mix;
                    r_step <= r_step + 1'b1;
                    if (r_step == 2'd2) begin
                        r_rem <= '0;
                        r_bit <= '0;
                        r_state <= (i_bucket_count == '0) ? S_OUT : S_DIV;
                    end
                end
                S_DIV: begin
                    r_bit <= r_bit + 1'b1;
                    if (!n_diff[HASH_W+1]) begin
                        r_rem <= n_diff[HASH_W-1:0];
                    end else begin
                        r_rem <= n_shift[HASH_W-1:0];
                    end
                    if (r_bit == SW'(HASH_W - 1)) begin
                        r_acc   <= (!n_diff[HASH_W+1]) ? n_diff[HASH_W-1:0]
                                                       : n_shift[HASH_W-1:0];
                        r_state <= S_OUT;
                    end else begin
                        r_acc <= {r_acc[HASH_W-2:0], 1'b0};
                    end
                end
                S_OUT: begin
                    if (o_bucket.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_rem_below_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < i_bucket_count))
        else $error("Partial remainder not below the bucket count.");

    a_result_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_bucket.valid && i_bucket_count != '0) |-> (r_acc < i_bucket_count))
        else $error("Bucket index not below the bucket count.");

    a_pop_only_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state == S_MIX && r_step == 2'd0))
        else $error("Queue entry taken without starting the final mix.");
`endif

endmodule

// ===== src/string_hash_bucket_index.sv =====
// Bucket index by the one-at-a-time string hash. Key bytes arrive one per
// transaction with end_of_key low and are folded into the running hash at one
// per cycle while the queue has room; a transaction with end_of_key high (its
// byte ignored) closes the key and queues the raw hash. A back stage applies
// the final mix and reduces it modulo bucket_count with a restoring divider
// that retires one bit per cycle; it takes the next queued key only after the
// current result has been accepted. When bucket_count is zero the divider is
// skipped and the full mixed hash is returned. The queue holds QUEUE_DEPTH
// finished keys; key bytes keep flowing while it has room. An empty key gives
// bucket 0. Write bucket_count only while idle.
module string_hash_bucket_index #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    shbi_key_if.sink       i_key,
    shbi_cfg_if.sink       i_cfg,
    shbi_bucket_if.source  o_bucket
);
    import shbi_pkg::*;

    t_hash      r_bucket_count;
    logic       q_push;
    t_hash      q_push_data;
    logic       q_pop;
    t_hash      q_pop_data;
    t_q_status  q_status;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= BUCKET_COUNT_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_bucket_count <= i_cfg.data;
        end
    end

    shbi_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_key      (i_key),
        .i_q_status (q_status),
        .o_q_push   (q_push),
        .o_q_data   (q_push_data)
    );

    shbi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .i_pop       (q_pop),
        .o_pop_data  (q_pop_data),
        .o_status    (q_status)
    );

    shbi_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_bucket_count (r_bucket_count),
        .i_q_data       (q_pop_data),
        .i_q_status     (q_status),
        .o_q_pop        (q_pop),
        .o_bucket       (o_bucket)
    );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

    import shbi_pkg::*;

    localparam int unsigned RESET_CYCLES   = 8;
    localparam int unsigned SETTLE_CYCLES  = 60;
    localparam int unsigned FINAL_CYCLES   = 100;
    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned MAX_REPORTS    = 10;
    localparam int unsigned PHASE_ITEMS    = 112;

    typedef struct packed {
        t_byte key_byte;
        logic  end_of_key;
    } t_key_xfer;

    logic i_clk;
    logic i_rst_n;

    shbi_key_if    key_if ();
    shbi_cfg_if    cfg_if ();
    shbi_bucket_if bucket_if ();

    string_hash_bucket_index uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_key    (key_if),
        .i_cfg    (cfg_if),
        .o_bucket (bucket_if)
    );

    t_key_xfer   pending_xfers[$];
    t_hash       expected_buckets[$];
    t_hash       model_bucket_count;
    t_hash       model_hash;
    int unsigned fail_count;
    int unsigned keys_closed;
    int unsigned bytes_folded;
    int unsigned buckets_checked;
    int unsigned settings_used;
    int unsigned idle_cycles;
    int unsigned cycle_count;
    int unsigned burst_left;
    int unsigned gap_left;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic t_hash fold_key_byte(t_hash h, t_byte b);
        t_hash r;
        r = h + {24'd0, b};
        r = r + (r << ABSORB_SHL);
        r = r ^ (r >> ABSORB_SHR);
        return r;
    endfunction

    function automatic t_hash avalanche(t_hash h);
        t_hash r;
        r = h + (h << MIX_SHL_A);
        r = r ^ (r >> MIX_SHR);
        r = r + (r << MIX_SHL_B);
        return r;
    endfunction

    function automatic t_hash bucket_of(t_hash mixed, t_hash count);
        return (count == '0) ? mixed : mixed % count;
    endfunction

    task automatic note_failure(string what, t_hash exp_val, t_hash act_val);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("[%0t] %s: expected %0d, got %0d", $time, what, exp_val, act_val);
        end
    endtask

    // Key transactions: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        t_key_xfer nxt;
        if (!i_rst_n) begin
            key_if.valid      <= 1'b0;
            key_if.key_byte   <= '0;
            key_if.end_of_key <= 1'b0;
            burst_left        <= 1;
            gap_left          <= 0;
        end else begin
            if (key_if.valid && key_if.ready) begin
                if (key_if.end_of_key) begin
                    expected_buckets.push_back(
                        bucket_of(avalanche(model_hash), model_bucket_count));
                    model_hash = '0;
                    keys_closed++;
                end else begin
                    model_hash = fold_key_byte(model_hash, key_if.key_byte);
                    bytes_folded++;
                end
            end
            if (!key_if.valid || key_if.ready) begin
                if (gap_left != 0) begin
                    gap_left     <= gap_left - 1;
                    key_if.valid <= 1'b0;
                end else if (pending_xfers.size() != 0) begin
                    nxt = pending_xfers.pop_front();
                    key_if.valid      <= 1'b1;
                    key_if.key_byte   <= nxt.key_byte;
                    key_if.end_of_key <= nxt.end_of_key;
                    if (burst_left <= 1) begin
                        burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(32, 96)
                                                                : $urandom_range(1, 16);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    key_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result side: the ready pattern rotates through four stall modes.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bucket_if.ready <= 1'b0;
            cycle_count     <= 0;
        end else begin
            cycle_count <= cycle_count + 1;
            case ((cycle_count >> 9) % 4)
                0: begin
                    bucket_if.ready <= 1'b1;
                end
                1: begin
                    bucket_if.ready <= ($urandom_range(0, 3) != 0);
                end
                2: begin
                    bucket_if.ready <= (cycle_count % 7 == 3);
                end
                default: begin
                    bucket_if.ready <= (cycle_count % 64 >= 60);
                end
            endcase
            if (bucket_if.valid && bucket_if.ready) begin
                if (expected_buckets.size() == 0) begin
                    note_failure("Unexpected bucket index", '0, bucket_if.bucket_index);
                end else begin
                    buckets_checked++;
                    if (bucket_if.bucket_index !== expected_buckets[0]) begin
                        note_failure("Bucket index mismatch", expected_buckets[0],
                                     bucket_if.bucket_index);
                    end
                    void'(expected_buckets.pop_front());
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (key_if.valid && key_if.ready) || (cfg_if.valid && cfg_if.ready)
                || (bucket_if.valid && bucket_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding.",
                     expected_buckets.size());
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_xfer(t_byte b, logic eok);
        t_key_xfer x;
        x.key_byte   = b;
        x.end_of_key = eok;
        pending_xfers.push_back(x);
    endtask

    task automatic add_key(int unsigned len, t_byte fill, bit random_fill);
        for (int unsigned i = 0; i < len; i++) begin
            add_xfer(random_fill ? t_byte'($urandom_range(0, 255)) : fill, 1'b0);
        end
        add_xfer(t_byte'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic wait_until_drained(int unsigned settle);
        do begin
            @(posedge i_clk);
        end while (pending_xfers.size() != 0 || key_if.valid || expected_buckets.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_bucket_count(t_hash count);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= count;
        do begin
            @(posedge i_clk);
        end while (!cfg_if.ready);
        model_bucket_count = count;
        cfg_if.valid <= 1'b0;
        settings_used++;
    endtask

    task automatic add_random_phase();
        int unsigned phase_items;
        int unsigned pick;
        int unsigned len;
        phase_items = 0;
        while (phase_items < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                len = $urandom_range(1, 8);
            end else if (pick < 85) begin
                len = 0;
            end else begin
                len = $urandom_range(9, 40);
            end
            if ($urandom_range(0, 9) == 0) begin
                add_key(len, ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00, 1'b0);
            end else begin
                add_key(len, '0, 1'b1);
            end
            phase_items += len + 1;
        end
    endtask

    initial begin
        t_hash settings[$];
        key_if.valid      = 1'b0;
        key_if.key_byte   = '0;
        key_if.end_of_key = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.data       = '0;
        bucket_if.ready   = 1'b0;
        i_rst_n           = 1'b0;
        model_bucket_count = BUCKET_COUNT_RESET;
        model_hash        = '0;
        fail_count        = 0;
        keys_closed       = 0;
        bytes_folded      = 0;
        buckets_checked   = 0;
        settings_used     = 1;
        idle_cycles       = 0;
        settings = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd2, 32'h8000_0000, 32'd7,
                     32'd13, 32'd0};
        settings[5] = t_hash'($urandom_range(3, 32'h7FFF_FFFF));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed keys under the reset bucket count, starting with empty keys.
        add_xfer(8'h00, 1'b1);
        add_xfer(8'hFF, 1'b1);
        add_xfer(8'h00, 1'b0);
        add_xfer(8'h00, 1'b1);
        add_xfer(8'hFF, 1'b0);
        add_xfer(8'h00, 1'b1);
        add_xfer(8'h80, 1'b0);
        add_xfer(8'h01, 1'b0);
        add_xfer(8'h7F, 1'b0);
        add_xfer(8'h55, 1'b1);
        add_key(6, 8'hFF, 1'b0);
        add_xfer(8'h61, 1'b0);
        add_xfer(8'h00, 1'b1);
        add_xfer(8'hAA, 1'b0);
        add_xfer(8'hFF, 1'b1);
        add_xfer(8'h12, 1'b1);
        add_xfer(8'h34, 1'b1);
        add_xfer(8'h56, 1'b1);
        add_random_phase();

        foreach (settings[i]) begin
            wait_until_drained(SETTLE_CYCLES);
            write_bucket_count(settings[i]);
            @(negedge i_clk);
            add_random_phase();
        end

        wait_until_drained(FINAL_CYCLES);
        if (expected_buckets.size() != 0) begin
            note_failure("Results still outstanding", '0, expected_buckets.size());
        end

        $display("Folded %0d key bytes into %0d keys under %0d bucket counts.",
                 bytes_folded, keys_closed, settings_used);
        $display("Checked %0d bucket indices; zero and all-ones counts included.",
                 buckets_checked);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
